// ===== rtl/core/joystick_drive_mixer_macros.svh =====
// Assertion macros for the joystick drive mixer RTL.
`ifndef JOYSTICK_DRIVE_MIXER_MACROS_SVH
`define JOYSTICK_DRIVE_MIXER_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define JDM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Condition in one cycle implies a consequence in the next.
`define JDM_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");
`else
`define JDM_ASSERT(lbl, prop)
`define JDM_ASSERT_NEXT(lbl, cond, cons)
`endif
`endif

// ===== rtl/core/jdm_pkg.sv =====
// Types, constants and the tangent table of the joystick drive mixer.
`default_nettype none
package jdm_pkg;

    localparam int CW       = 16;          // coordinate width
    localparam int RW       = 10;          // range width
    localparam int RADW     = 15;          // radius width
    localparam int DUTYW    = 7;
    localparam int LIMW     = (RW > 10) ? RW : 10;
    localparam int TW       = 20;          // tangent table width
    localparam int PRODW    = CW + TW;
    localparam int SQW      = 2 * CW + 2;  // radicand, whole bit pairs
    localparam int SQ_STEPS = CW + 1;
    localparam int ROOTW    = CW + 1;
    localparam int REMW     = CW + 4;
    localparam int RCW      = (ROOTW > RADW) ? ROOTW : RADW;
    localparam int NUMW     = 22;          // radius * 100
    localparam int QW       = 7;
    localparam int DIV_STEPS = 7;
    localparam int NCELL    = 45;
    localparam int CELLW    = 6;
    localparam int CNTW     = 6;

    localparam logic [TW-1:0] TAN_ONE = 20'd1000000;
    localparam logic [CELLW-1:0] SPIN_K = 6'd43;
    localparam logic [13:0] RECIP90 = 14'd11651;  // ceil(2^20 / 90)

    localparam logic [2:0] MOT_STOP  = 3'd0;
    localparam logic [2:0] MOT_FWD   = 3'd1;
    localparam logic [2:0] MOT_BACK  = 3'd2;
    localparam logic [2:0] MOT_LEFT  = 3'd3;
    localparam logic [2:0] MOT_RIGHT = 3'd4;

    localparam logic [1:0] REG_MIN_SPEED  = 2'd0;
    localparam logic [1:0] REG_NEAR_LIMIT = 2'd1;
    localparam logic [1:0] REG_SPIN_DUTY  = 2'd2;

    typedef enum logic [2:0] {
        DS_ZERO = 3'b001,
        DS_SPIN = 3'b010,
        DS_MIX  = 3'b100
    } dsel_t;

    typedef struct packed {
        logic [DUTYW-1:0] min_speed;
        logic [9:0]       near_limit;
        logic [DUTYW-1:0] spin_duty;
    } cfg_t;

    typedef struct packed {
        logic [CW-1:0]    ax;
        logic [CW-1:0]    ay;
        logic             xneg;
        logic             yneg;
        logic [PRODW-1:0] ax1e6;
        logic [PRODW-1:0] ay1e6;
        logic [PRODW-1:0] axt43;
        logic [RADW-1:0]  r;
        logic [RW-1:0]    rng;
        logic             a_clr;
        logic             b_clr;
        logic [SQW-1:0]   nsh;
        logic [REMW-1:0]  rem;
        logic [ROOTW-1:0] root;
        logic [NUMW-1:0]  num;
        logic [QW-1:0]    q;
        logic [CNTW-1:0]  cntle;
        logic [CNTW-1:0]  cntlt;
    } item_t;

    // round(tan((k+1) deg) * 1e6)
    function automatic logic [TW-1:0] tank(input logic [CELLW-1:0] k);
        logic [TW-1:0] t;
        case (k)
            6'd0:  t = 20'd17455;   6'd1:  t = 20'd34921;   6'd2:  t = 20'd52408;
            6'd3:  t = 20'd69927;   6'd4:  t = 20'd87489;   6'd5:  t = 20'd105104;
            6'd6:  t = 20'd122785;  6'd7:  t = 20'd140541;  6'd8:  t = 20'd158384;
            6'd9:  t = 20'd176327;  6'd10: t = 20'd194380;  6'd11: t = 20'd212557;
            6'd12: t = 20'd230868;  6'd13: t = 20'd249328;  6'd14: t = 20'd267949;
            6'd15: t = 20'd286745;  6'd16: t = 20'd305731;  6'd17: t = 20'd324920;
            6'd18: t = 20'd344328;  6'd19: t = 20'd363970;  6'd20: t = 20'd383864;
            6'd21: t = 20'd404026;  6'd22: t = 20'd424475;  6'd23: t = 20'd445229;
            6'd24: t = 20'd466308;  6'd25: t = 20'd487733;  6'd26: t = 20'd509525;
            6'd27: t = 20'd531709;  6'd28: t = 20'd554309;  6'd29: t = 20'd577350;
            6'd30: t = 20'd600861;  6'd31: t = 20'd624869;  6'd32: t = 20'd649408;
            6'd33: t = 20'd674509;  6'd34: t = 20'd700208;  6'd35: t = 20'd726543;
            6'd36: t = 20'd753554;  6'd37: t = 20'd781286;  6'd38: t = 20'd809784;
            6'd39: t = 20'd839100;  6'd40: t = 20'd869287;  6'd41: t = 20'd900404;
            6'd42: t = 20'd932515;  6'd43: t = 20'd965689;
            default: t = TAN_ONE;
        endcase
        return t;
    endfunction

    function automatic logic [DUTYW-1:0] sat100(input logic [DUTYW-1:0] v);
        return (v > 7'd100) ? 7'd100 : v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/joystick_drive_mixer.sv =====
// Top level: config registers, input register, cell chain and output stage.
//
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | stick_x, stick_y, stick_radius, range_cm, sensor_*_clear
//  out     | out_valid / out_stall| motion, duty_a, duty_b, running
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// One transaction per cycle while the chain is not held; input register, 45 cells, two output stages.
// Latency is set by the 45-cell angle chain, one tangent threshold per cell.
// Reset clears all valid bits and loads the register defaults (40, 50, 100).
// While out_valid and out_stall are both high the whole chain holds and in_stall is raised.
`default_nettype none
module joystick_drive_mixer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [jdm_pkg::CW-1:0] stick_x,
    input  wire logic signed [jdm_pkg::CW-1:0] stick_y,
    input  wire logic [jdm_pkg::RADW-1:0]      stick_radius,
    input  wire logic [jdm_pkg::RW-1:0]        range_cm,
    input  wire logic                          sensor_a_clear,
    input  wire logic                          sensor_b_clear,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         motion,
    output logic [jdm_pkg::DUTYW-1:0]          duty_a,
    output logic [jdm_pkg::DUTYW-1:0]          duty_b,
    output logic                               running,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [9:0]                    cfg_data
);
    import jdm_pkg::*;

    cfg_t             cfg_reg;
    logic             en;
    logic             s0_valid_reg;
    logic [CW-1:0]    s0_x_reg, s0_y_reg;
    logic [RADW-1:0]  s0_r_reg;
    logic [RW-1:0]    s0_rng_reg;
    logic             s0_a_reg, s0_b_reg;
    item_t            entry;
    logic [CW-1:0]    ax, ay;
    logic             xneg, yneg;
    logic             v [0:NCELL];
    item_t            it [0:NCELL];

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_speed  <= 7'd40;
            cfg_reg.near_limit <= 10'd50;
            cfg_reg.spin_duty  <= 7'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_SPEED:  cfg_reg.min_speed  <= cfg_data[6:0];
                REG_NEAR_LIMIT: cfg_reg.near_limit <= cfg_data;
                REG_SPIN_DUTY:  cfg_reg.spin_duty  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_x_reg   <= stick_x;
            s0_y_reg   <= stick_y;
            s0_r_reg   <= stick_radius;
            s0_rng_reg <= range_cm;
            s0_a_reg   <= sensor_a_clear;
            s0_b_reg   <= sensor_b_clear;
        end
    end

    // magnitudes, radicand and scaled products feeding the first cell
    always_comb
    begin
        xneg        = s0_x_reg[CW-1];
        yneg        = s0_y_reg[CW-1];
        ax          = xneg ? (~s0_x_reg + 1'b1) : s0_x_reg;
        ay          = yneg ? (~s0_y_reg + 1'b1) : s0_y_reg;
        entry       = '0;
        entry.ax    = ax;
        entry.ay    = ay;
        entry.xneg  = xneg;
        entry.yneg  = yneg;
        entry.ax1e6 = PRODW'(ax) * PRODW'(TAN_ONE);
        entry.ay1e6 = PRODW'(ay) * PRODW'(TAN_ONE);
        entry.axt43 = PRODW'(ax) * PRODW'(tank(SPIN_K));
        entry.r     = s0_r_reg;
        entry.rng   = s0_rng_reg;
        entry.a_clr = s0_a_reg;
        entry.b_clr = s0_b_reg;
        entry.nsh   = SQW'(ax) * SQW'(ax) + SQW'(ay) * SQW'(ay);
    end

    assign v[0]  = s0_valid_reg;
    assign it[0] = entry;

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        jdm_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .idx  (CELLW'(g)),
            .vin  (v[g]),
            .din  (it[g]),
            .vout (v[g+1]),
            .dout (it[g+1])
        );
    end

    jdm_tail u_tail (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .cfg      (cfg_reg),
        .vin      (v[NCELL]),
        .din      (it[NCELL]),
        .out_valid(out_valid),
        .motion   (motion),
        .duty_a   (duty_a),
        .duty_b   (duty_b),
        .running  (running)
    );

endmodule
`default_nettype wire

// ===== rtl/core/jdm_cell.sv =====
// One cell of the chain: angle compare, plus in the early cells a root or a division step.
`default_nettype none
module jdm_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic [jdm_pkg::CELLW-1:0] idx,
    input  wire logic                      vin,
    input  wire jdm_pkg::item_t            din,
    output logic                           vout,
    output jdm_pkg::item_t                 dout
);
    import jdm_pkg::*;

    logic             v_reg;
    item_t            d_reg;
    item_t            d_next;
    logic [PRODW-1:0] prod;
    logic [REMW-1:0]  rem_t;
    logic [REMW-1:0]  trial;
    logic [ROOTW-1:0] root_new;
    logic [RCW-1:0]   root_x;
    logic [RCW-1:0]   r_x;
    logic [RADW-1:0]  dclamp;
    logic [2:0]       bsel;
    logic [NUMW-1:0]  sub;

    always_comb
    begin
        d_next   = din;
        // angle: one tangent threshold per cell
        prod = PRODW'(din.ay) * PRODW'(tank(idx));
        if (prod <= din.ax1e6)
            d_next.cntle = din.cntle + 1'b1;
        if (prod < din.ax1e6)
            d_next.cntlt = din.cntlt + 1'b1;

        // square root, one bit pair per cell
        rem_t    = {din.rem[REMW-3:0], din.nsh[SQW-1:SQW-2]};
        trial    = REMW'({din.root, 2'b01});
        root_new = {din.root[ROOTW-2:0], 1'b0};
        root_x   = '0;
        r_x      = RCW'(din.r);
        dclamp   = '0;
        bsel     = 3'(DIV_STEPS - 1) - 3'(idx - CELLW'(SQ_STEPS));
        sub      = NUMW'(din.r) << bsel;
        if (idx < CELLW'(SQ_STEPS))
        begin
            if (rem_t >= trial)
            begin
                d_next.rem = rem_t - trial;
                root_new   = {din.root[ROOTW-2:0], 1'b1};
            end
            else
                d_next.rem = rem_t;
            d_next.root = root_new;
            d_next.nsh  = {din.nsh[SQW-3:0], 2'b00};
            // last root step: clamp to radius, scale by 100
            if (idx == CELLW'(SQ_STEPS - 1))
            begin
                root_x     = RCW'(root_new);
                dclamp     = (root_x > r_x) ? din.r : RADW'(root_x);
                d_next.num = NUMW'(dclamp) * NUMW'(100);
                d_next.q   = '0;
            end
        end
        // restoring division step for speed = num / r
        else if (idx < CELLW'(SQ_STEPS + DIV_STEPS))
        begin
            if (din.num >= sub)
            begin
                d_next.num     = din.num - sub;
                d_next.q[bsel] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign vout = v_reg;
    assign dout = d_reg;

endmodule
`default_nettype wire

// ===== rtl/core/jdm_tail.sv =====
// Mix and obstacle decision, then output register.
`default_nettype none
`include "joystick_drive_mixer_macros.svh"
module jdm_tail (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire jdm_pkg::cfg_t             cfg,
    input  wire logic                      vin,
    input  wire jdm_pkg::item_t            din,
    output logic                           out_valid,
    output logic [2:0]                     motion,
    output logic [jdm_pkg::DUTYW-1:0]      duty_a,
    output logic [jdm_pkg::DUTYW-1:0]      duty_b,
    output logic                           running
);
    import jdm_pkg::*;

    // stage A
    logic             a_valid_reg;
    logic [13:0]      a_p_reg,     a_p_next;
    logic [DUTYW-1:0] a_speed_reg, a_speed_next;
    logic [2:0]       a_mot_reg,   a_mot_next;
    logic             a_run_reg,   a_run_next;
    dsel_t            a_ds_reg,    a_ds_next;
    logic             a_slow_a_reg, a_slow_a_next;
    logic [DUTYW-1:0] a_spin_reg,  a_spin_next;
    // stage B
    logic             out_valid_reg;
    logic [2:0]       mot_reg,  mot_next;
    logic [DUTYW-1:0] da_reg,   da_next;
    logic [DUTYW-1:0] db_reg,   db_next;
    logic             run_reg,  run_next;

    logic             spinl, spinr, near, fwd;
    logic [DUTYW-1:0] minsp, f;
    logic [27:0]      sc_prod;
    logic [DUTYW-1:0] scaled;

    // stage A: speed, angle factor, motion decision
    always_comb
    begin
        minsp        = sat100(cfg.min_speed);
        a_spin_next  = sat100(cfg.spin_duty);
        a_speed_next = (din.q < minsp) ? minsp : din.q;
        spinl        = din.xneg && (din.ay1e6 <= din.axt43);
        spinr        = !din.xneg && (din.ax != '0) && (din.ay < din.ax);
        near         = (din.rng != '0) && (LIMW'(din.rng) < LIMW'(cfg.near_limit));
        fwd          = (din.ay != '0) && !din.yneg;
        if (din.ax == '0)
            f = 7'd90;
        else if (din.xneg)
            f = (din.ay < din.ax) ? 7'd45 : 7'd90 - 7'(din.cntle);
        else
            f = 7'd89 - 7'(din.cntlt);
        a_p_next      = 14'(a_speed_next) * 14'(f);
        a_slow_a_next = din.xneg;

        a_mot_next = MOT_STOP;
        a_ds_next  = DS_ZERO;
        a_run_next = 1'b0;
        if (din.r == '0)
        begin
            a_mot_next = MOT_STOP;
        end
        else if (spinl)
        begin
            a_mot_next = MOT_LEFT;  a_ds_next = DS_SPIN; a_run_next = 1'b1;
        end
        else if (spinr)
        begin
            a_mot_next = MOT_RIGHT; a_ds_next = DS_SPIN; a_run_next = 1'b1;
        end
        else if (fwd)
        begin
            a_ds_next  = DS_SPIN;
            a_run_next = 1'b1;
            if (near)
            begin
                if (!din.a_clr && !din.b_clr)
                begin
                    a_mot_next = MOT_LEFT; a_run_next = 1'b0;
                end
                else if (!din.a_clr)
                    a_mot_next = MOT_RIGHT;
                else
                    a_mot_next = MOT_LEFT;
            end
            else if (!din.a_clr)
                a_mot_next = MOT_RIGHT;
            else if (!din.b_clr)
                a_mot_next = MOT_LEFT;
            else
            begin
                a_mot_next = MOT_FWD; a_ds_next = DS_MIX;
            end
        end
        else if (din.ay != '0)
        begin
            a_mot_next = MOT_BACK; a_ds_next = DS_MIX; a_run_next = 1'b1;
        end
    end

    // stage B: slow wheel = p / 90 by reciprocal, exact for p below 74898
    always_comb
    begin
        sc_prod  = 28'(a_p_reg) * 28'(RECIP90);
        scaled   = sc_prod[26:20];
        mot_next = a_mot_reg;
        run_next = a_run_reg;
        case (a_ds_reg)
            DS_SPIN:
            begin
                da_next = a_spin_reg;
                db_next = a_spin_reg;
            end
            DS_MIX:
            begin
                da_next = a_slow_a_reg ? scaled : a_speed_reg;
                db_next = a_slow_a_reg ? a_speed_reg : scaled;
            end
            default:
            begin
                da_next = '0;
                db_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= vin;
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_p_reg      <= a_p_next;
            a_speed_reg  <= a_speed_next;
            a_mot_reg    <= a_mot_next;
            a_run_reg    <= a_run_next;
            a_ds_reg     <= a_ds_next;
            a_slow_a_reg <= a_slow_a_next;
            a_spin_reg   <= a_spin_next;
            mot_reg      <= mot_next;
            da_reg       <= da_next;
            db_reg       <= db_next;
            run_reg      <= run_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign motion    = mot_reg;
    assign duty_a    = da_reg;
    assign duty_b    = db_reg;
    assign running   = run_reg;

    `JDM_ASSERT(a_stop_quiet, out_valid && motion == MOT_STOP |-> duty_a == '0 && duty_b == '0 && !running)
    `JDM_ASSERT(a_duty_range, out_valid |-> duty_a <= 7'd100 && duty_b <= 7'd100)
    `JDM_ASSERT(a_drive_runs, out_valid && (motion == MOT_FWD || motion == MOT_BACK) |-> running)
    `JDM_ASSERT_NEXT(a_stage_adv, en && a_valid_reg, out_valid)

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the joystick drive mixer: predicted results against the block.
module tb_top;
    import jdm_pkg::*;

    // tan(k deg) * 1e6 rounded, k = 1..45
    localparam longint TAN_TBL [45] = '{
        17455, 34921, 52408, 69927, 87489, 105104, 122785, 140541,
        158384, 176327, 194380, 212557, 230868, 249328, 267949, 286745,
        305731, 324920, 344328, 363970, 383864, 404026, 424475, 445229,
        466308, 487733, 509525, 531709, 554309, 577350, 600861, 624869,
        649408, 674509, 700208, 726543, 753554, 781286, 809784, 839100,
        869287, 900404, 932515, 965689, 1000000};
    localparam longint MILLION = 1000000;

    typedef struct packed {
        logic [2:0]       motion;
        logic [DUTYW-1:0] duty_a;
        logic [DUTYW-1:0] duty_b;
        logic             running;
    } drive_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [CW-1:0] stick_x = '0;
    logic signed [CW-1:0] stick_y = '0;
    logic [RADW-1:0] stick_radius = '0;
    logic [RW-1:0] range_cm = '0;
    logic sensor_a_clear = 1'b0;
    logic sensor_b_clear = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] motion;
    logic [DUTYW-1:0] duty_a;
    logic [DUTYW-1:0] duty_b;
    logic running;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [9:0] cfg_data = '0;

    // shadow of the configuration registers
    int unsigned min_spd = 40;
    int unsigned near_lim = 50;
    int unsigned spin_pct = 100;

    drive_cmd_t expected_cmds[$];
    int errors = 0;
    bit sender_idles = 1'b1;
    bit recv_idles = 1'b1;
    bit recv_hold = 1'b0;

    joystick_drive_mixer dut (.*);

    always #5 clk = ~clk;

    function automatic longint int_sqrt(input longint n);
        longint lo, hi, mid;
        lo = 0;
        hi = 46342;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= n) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic drive_cmd_t mix_drive(input logic signed [CW-1:0] sx,
                                             input logic signed [CW-1:0] sy,
                                             input logic [RADW-1:0] rad,
                                             input logic [RW-1:0] rng,
                                             input logic a_clr, input logic b_clr);
        drive_cmd_t res;
        longint ax, ay, mag, spd, c, da, db;
        logic [DUTYW-1:0] sp, mn;
        sp = (spin_pct > 100) ? 7'd100 : DUTYW'(spin_pct);
        mn = (min_spd > 100) ? 7'd100 : DUTYW'(min_spd);
        ax = (sx < 0) ? -longint'(sx) : longint'(sx);
        ay = (sy < 0) ? -longint'(sy) : longint'(sy);
        if (rad == 0) return '{MOT_STOP, 0, 0, 1'b0};
        mag = int_sqrt(ax * ax + ay * ay);
        if (mag > rad) mag = rad;
        spd = mag * 100 / rad;
        if (spd < mn) spd = mn;
        if (ax == 0) begin
            da = spd;
            db = spd;
        end else if (sx < 0) begin
            if (ay * MILLION <= ax * TAN_TBL[43]) return '{MOT_LEFT, sp, sp, 1'b1};
            if (ay < ax) c = 45;
            else begin
                c = 90;
                for (int k = 0; k < 45; k++)
                    if (ay * TAN_TBL[k] <= ax * MILLION) c--;
            end
            db = spd;
            da = spd * c / 90;
        end else begin
            if (ay < ax) return '{MOT_RIGHT, sp, sp, 1'b1};
            c = 1;
            for (int k = 0; k < 45; k++)
                if (ay * TAN_TBL[k] < ax * MILLION) c++;
            da = spd;
            db = spd * (90 - c) / 90;
        end
        if (ay != 0 && sy > 0) begin
            if (rng != 0 && rng < near_lim) begin
                if (!a_clr && !b_clr) return '{MOT_LEFT, sp, sp, 1'b0};
                if (!a_clr) return '{MOT_RIGHT, sp, sp, 1'b1};
                return '{MOT_LEFT, sp, sp, 1'b1};
            end
            if (!a_clr) return '{MOT_RIGHT, sp, sp, 1'b1};
            if (!b_clr) return '{MOT_LEFT, sp, sp, 1'b1};
            res = '{MOT_FWD, DUTYW'(da), DUTYW'(db), 1'b1};
            return res;
        end
        if (ay != 0) return '{MOT_BACK, DUTYW'(da), DUTYW'(db), 1'b1};
        return '{MOT_STOP, 0, 0, 1'b0};
    endfunction

    // send one transaction, at times with a random idle burst ahead of it
    task automatic send_stick(input logic signed [CW-1:0] sx, input logic signed [CW-1:0] sy,
                              input logic [RADW-1:0] rad, input logic [RW-1:0] rng,
                              input logic a_clr, input logic b_clr);
        int gap;
        gap = 0;
        if (sender_idles && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        stick_x <= sx;
        stick_y <= sy;
        stick_radius <= rad;
        range_cm <= rng;
        sensor_a_clear <= a_clr;
        sensor_b_clear <= b_clr;
        expected_cmds.push_back(mix_drive(sx, sy, rad, rng, a_clr, b_clr));
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MIN_SPEED: min_spd = val[6:0];
            REG_NEAR_LIMIT: near_lim = val;
            REG_SPIN_DUTY: spin_pct = val[6:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic send_random(input int n, input bit edge_heavy);
        logic signed [CW-1:0] sx, sy;
        logic [RADW-1:0] rad;
        for (int i = 0; i < n; i++) begin
            sx = CW'($urandom);
            sy = CW'($urandom);
            if ($urandom_range(0, 3) == 0) begin
                sx = CW'(int'($urandom_range(0, 300)) - 150);
                sy = CW'(int'($urandom_range(0, 300)) - 150);
            end
            if (edge_heavy && $urandom_range(0, 7) == 0) sx = 0;
            if (edge_heavy && $urandom_range(0, 7) == 0) sy = 0;
            case ($urandom_range(0, 3))
                0: rad = RADW'($urandom_range(1, 300));
                1: rad = RADW'($urandom);
                2: rad = RADW'($urandom_range(0, 3));
                default: rad = RADW'($urandom_range(20000, 32767));
            endcase
            send_stick(sx, sy, rad,
                       RW'($urandom_range(0, 3) == 0 ? $urandom_range(0, 80) : $urandom),
                       $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
        end
    endtask

    task automatic test_directed;
        send_stick(0, 0, 0, 0, 1, 1);
        send_stick(16'sh7fff, 16'sh7fff, 15'h7fff, 10'h3ff, 1, 1);
        send_stick(-16'sh8000, -16'sh8000, 15'h7fff, 10'h3ff, 1, 1);
        send_stick(-16'sh8000, 16'sh7fff, 1, 0, 1, 1);
        send_stick(0, 100, 200, 0, 1, 1);
        send_stick(0, -100, 200, 0, 1, 1);
        send_stick(0, 0, 200, 0, 1, 1);
        send_stick(100, 50, 200, 0, 1, 1);
        send_stick(100, 100, 200, 0, 1, 1);
        send_stick(-100, 96, 200, 0, 1, 1);
        send_stick(-100, 97, 200, 0, 1, 1);
        send_stick(-100, 200, 300, 0, 1, 1);
        send_stick(-100, -300, 400, 0, 1, 1);
        send_stick(50, -300, 400, 0, 1, 1);
        send_stick(10, 300, 400, 10, 0, 0);
        send_stick(10, 300, 400, 10, 0, 1);
        send_stick(10, 300, 400, 10, 1, 0);
        send_stick(10, 300, 400, 49, 1, 1);
        send_stick(10, 300, 400, 50, 0, 1);
        send_stick(10, 300, 400, 60, 1, 0);
        send_stick(10, 300, 400, 0, 0, 0);
        send_stick(-40, 500, 32767, 200, 1, 1);
        send_stick(1, -1, 32767, 0, 1, 1);
    endtask

    task automatic test_register_sweep;
        write_reg(REG_MIN_SPEED, 0);
        write_reg(REG_NEAR_LIMIT, 1023);
        write_reg(REG_SPIN_DUTY, 0);
        send_random(200, 1'b1);
        drain();
        write_reg(REG_MIN_SPEED, 10'h07f);
        write_reg(REG_NEAR_LIMIT, 0);
        write_reg(REG_SPIN_DUTY, 10'h3ff);
        send_random(200, 1'b1);
        drain();
        write_reg(REG_MIN_SPEED, 100);
        write_reg(REG_NEAR_LIMIT, 1);
        write_reg(REG_SPIN_DUTY, 101);
        send_random(150, 1'b1);
        drain();
        write_reg(REG_MIN_SPEED, 10'($urandom_range(1, 99)));
        write_reg(REG_NEAR_LIMIT, 10'($urandom_range(20, 120)));
        write_reg(REG_SPIN_DUTY, 10'($urandom_range(1, 99)));
    endtask

    // receiver holds off for a long stretch so the pipeline backs up
    task automatic test_backpressure;
        recv_hold = 1'b1;
        fork
            begin
                repeat (200) @(posedge clk);
                recv_hold = 1'b0;
            end
            send_random(150, 1'b0);
        join
    endtask

    task automatic test_random_traffic;
        send_random(900, 1'b0);
        sender_idles = 1'b0;
        recv_idles = 1'b0;
        send_random(200, 1'b0);
    endtask

    // receiver stall bursts
    initial begin
        int burst;
        forever begin
            @(posedge clk);
            if (recv_hold) out_stall <= 1'b1;
            else if (recv_idles && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 18);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end else out_stall <= 1'b0;
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge clk) begin
        drive_cmd_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_cmds.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result motion=%0d", motion);
            end else begin
                want = expected_cmds.pop_front();
                if (want != {motion, duty_a, duty_b, running}) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp m=%0d a=%0d b=%0d r=%0d got m=%0d a=%0d b=%0d r=%0d",
                                 want.motion, want.duty_a, want.duty_b, want.running,
                                 motion, duty_a, duty_b, running);
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        drain();
        test_register_sweep();
        test_backpressure();
        test_random_traffic();
        drain();
        if (expected_cmds.size() != 0) errors++;
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
